@@ rtl/srht_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srht_pkg: shared definitions for the swap-remove handle table
// Sizes, operation and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package srht_pkg;

	localparam int TABLE_SLOTS = 96;
	localparam int HANDLE_BITS = 16;
	localparam int KEY_W       = 16;
	localparam int MODE_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int IDX_W       = $clog2(TABLE_SLOTS);
	localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

	localparam logic [KEY_W-1:0] SPECIAL_KEY = 16'h21CA;
	localparam logic [KEY_W-1:0] NULL_KEY    = '0;

	localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESTORE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
	localparam logic [STATUS_W-1:0] ST_SKIPPED = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_FETCH,
		S_SWAP,
		S_OUT
	} state_t;

endpackage

@@ rtl/swap_remove_handle_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swap_remove_handle_table_core: handle table with swap-on-remove
// Slot zero holds the primary handle; other slots live in a memory with one read and one write port.
// ----------------------------------------------------------------------------
// One word is taken at a time and the input stays not ready until its result
// has been placed in the output register. Insert, restore and skipped or full
// operations pass from acceptance through the decode state to the output. A
// remove of a handle not in slot zero is settled by one comparator that walks
// the table one slot per cycle over the single read port of the handle
// memory; a hit moves the last live slot into the found one. The memory needs
// no clearing pass after reset; slots above the live count are never read.
module swap_remove_handle_table_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// handle_id [15:0], entry_key [31:16]
	input  logic [31:0]                      s_tdata,
	// mode [1:0]
	input  logic [srht_pkg::MODE_W-1:0]      s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// slot_index [6:0], entry_count [13:7], zeros [15:14]
	output logic [15:0]                      m_tdata,
	// status [1:0]
	output logic [srht_pkg::STATUS_W-1:0]    m_tuser,
	input  logic                             cfg_we,
	input  logic [srht_pkg::HANDLE_BITS-1:0] cfg_wdata
);
	import srht_pkg::*;

	state_t state_q, state_nxt;

	logic [MODE_W-1:0]      mode_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [KEY_W-1:0]       key_q;
	logic [HANDLE_BITS-1:0] default_q;
	logic [HANDLE_BITS-1:0] slot0_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       scan_q;
	logic                   vld_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [IDX_W-1:0]       found_q;
	logic [HANDLE_BITS-1:0] rdata_q;
	logic [STATUS_W-1:0]    res_status_q;
	logic [IDX_W-1:0]       res_idx_q;

	logic                   m_tvalid_q;
	logic [STATUS_W-1:0]    m_status_q;
	logic [IDX_W-1:0]       m_idx_q;
	logic [CNT_W-1:0]       m_count_q;

	logic [HANDLE_BITS-1:0] mem [TABLE_SLOTS];

	logic                   s_accept;
	logic                   issue;
	logic                   hit;
	logic                   out_free;
	logic [IDX_W-1:0]       last_idx;
	logic [IDX_W-1:0]       rd_addr;
	logic                   mem_we;
	logic [IDX_W-1:0]       mem_wa;
	logic [HANDLE_BITS-1:0] mem_wd;

	assign s_tready = (state_q == S_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign last_idx = IDX_W'(count_q - 1'b1);

	// One comparator serves the whole scan: it checks the word read last cycle.
	assign issue = (scan_q < count_q);
	assign hit   = vld_s1 && (rdata_q == handle_q);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_accept) state_nxt = S_DECODE;
			end
			S_DECODE: begin
				if (mode_q == MODE_REMOVE && key_q != NULL_KEY && slot0_q != handle_q)
					state_nxt = S_SCAN;
				else
					state_nxt = S_OUT;
			end
			S_SCAN: begin
				if (hit)
					state_nxt = S_FETCH;
				else if (!issue && !vld_s1)
					state_nxt = S_OUT;
			end
			S_FETCH: state_nxt = S_SWAP;
			S_SWAP:  state_nxt = S_OUT;
			S_OUT: begin
				if (out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Memory port control
	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = IDX_W'(count_q);
		mem_wd  = handle_q;
		rd_addr = scan_q[IDX_W-1:0];
		case (state_q)
			S_DECODE: begin
				mem_we = (mode_q == MODE_INSERT) && (key_q != SPECIAL_KEY) &&
				         (count_q < CNT_W'(TABLE_SLOTS));
			end
			S_FETCH: rd_addr = last_idx;
			S_SWAP: begin
				mem_we = 1'b1;
				mem_wa = found_q;
				mem_wd = rdata_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			default_q    <= '0;
			slot0_q      <= '0;
			count_q      <= CNT_W'(1);
			scan_q       <= '0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			found_q      <= '0;
			res_status_q <= ST_DONE;
			res_idx_q    <= '0;
			m_tvalid_q   <= 1'b0;
			m_status_q   <= ST_DONE;
			m_idx_q      <= '0;
			m_count_q    <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) default_q <= cfg_wdata;
			if (m_tvalid_q && m_tready && state_q != S_OUT) m_tvalid_q <= 1'b0;

			case (state_q)
				S_DECODE: begin
					res_status_q <= ST_DONE;
					res_idx_q    <= '0;
					scan_q       <= CNT_W'(1);
					vld_s1       <= 1'b0;
					case (mode_q)
						MODE_INSERT: begin
							if (key_q == SPECIAL_KEY) begin
								slot0_q <= handle_q;
							end else if (count_q >= CNT_W'(TABLE_SLOTS)) begin
								res_status_q <= ST_FULL;
							end else begin
								res_idx_q <= IDX_W'(count_q);
								count_q   <= count_q + 1'b1;
							end
						end
						MODE_REMOVE: begin
							if (key_q == NULL_KEY) begin
								res_status_q <= ST_SKIPPED;
							end else if (slot0_q == handle_q) begin
								slot0_q <= default_q;
							end
						end
						MODE_RESTORE: begin
							slot0_q <= default_q;
							count_q <= CNT_W'(1);
						end
						default: res_status_q <= ST_SKIPPED;
					endcase
				end
				S_SCAN: begin
					vld_s1 <= issue;
					idx_s1 <= scan_q[IDX_W-1:0];
					if (issue) scan_q <= scan_q + 1'b1;
					if (hit) begin
						found_q   <= idx_s1;
						res_idx_q <= idx_s1;
					end else if (!issue && !vld_s1) begin
						res_status_q <= ST_MISSING;
					end
				end
				S_SWAP: begin
					count_q <= count_q - 1'b1;
				end
				S_OUT: begin
					// A word still held by the output is taken in this same cycle.
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_status_q <= res_status_q;
						m_idx_q    <= res_idx_q;
						m_count_q  <= count_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			mode_q   <= s_tuser;
			handle_q <= s_tdata[HANDLE_BITS-1:0];
			key_q    <= s_tdata[31:16];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {2'b00, m_count_q, m_idx_q};

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(1) && count_q <= CNT_W'(TABLE_SLOTS))
		else $error("live count left its legal range");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> !s_tready)
		else $error("input ready right after a word was accepted");

	a_swap_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SWAP |=> count_q == $past(count_q) - 1'b1)
		else $error("swap remove did not drop the live count by one");

	a_hit_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && hit) |-> (CNT_W'(idx_s1) < count_q && idx_s1 != '0))
		else $error("scan matched outside the live slots");

endmodule
